// ===== sv/cds_pkg.sv =====
// Shared types, operation codes and calendar helpers for the date subtract core.
package cds_pkg;

  localparam logic [2:0] OP_DAYS    = 3'd0;
  localparam logic [2:0] OP_WEEKS   = 3'd1;
  localparam logic [2:0] OP_MONTHS  = 3'd2;
  localparam logic [2:0] OP_YEARS   = 3'd3;
  localparam logic [2:0] OP_DECADES = 3'd4;

  localparam logic [13:0] MaxYear = 14'd9999;

  typedef struct packed {
    logic [2:0]  operation;
    logic [9:0]  amount;
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
  } in_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic        year_underflow;
  } out_t;

  // Command to the year residue tracker.
  typedef struct packed {
    logic        load;
    logic        dec;
    logic [13:0] year;
  } trk_cmd_t;

  // Status from the year residue tracker.
  typedef struct packed {
    logic busy;
    logic leap;
  } trk_sts_t;

  function automatic logic [4:0] days_in(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/calendar_date_subtract_core.sv =====
// Top level: sequencer that moves a Gregorian date back by days, weeks, months, years or decades.
// Steps: the tracker reduces the year, then amount or 7*amount day steps (one per
//   cycle), a month division by repeated subtraction of 12 or a year subtraction,
//   with a second reduction after months and years; one beat is in flight at a time.
// Result appears on result_o with a one-cycle done_o strobe; the receiver cannot stall.
// Reset clears the sequencer and the strobe; result payload is left unreset.
module calendar_date_subtract_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cds_pkg::in_t  item_i,
  output logic          done_o,
  output cds_pkg::out_t result_o
);
  import cds_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_INIT,
    ST_DAY,
    ST_MDIV,
    ST_MAPPLY,
    ST_YAPPLY,
    ST_FIN
  } state_e;

  state_e      state_q;
  logic [2:0]  op_q;
  logic [9:0]  amt_q;
  logic [4:0]  day_q;
  logic [3:0]  month_q;
  logic [13:0] year_q;
  logic [12:0] steps_q;
  logic [6:0]  yc_q;
  logic        second_q;
  logic        done_q;
  out_t        result_q;

  trk_cmd_t    trk_cmd;
  trk_sts_t    trk_sts;

  logic [13:0] yr_in;
  logic [3:0]  mon_in;
  logic [13:0] sub_y;
  logic        y_under;
  logic        borrow;
  logic [3:0]  m_sub;
  logic [13:0] ysub_m;
  logic        m_under;
  logic [4:0]  n_len;
  logic [4:0]  prev_len;
  logic [4:0]  clamp_d;
  logic [12:0] steps_init;
  logic [13:0] yr_new;

  // Repair the incoming date fields.
  assign yr_in  = (item_i.start_year > MaxYear) ? MaxYear : item_i.start_year;
  assign mon_in = (item_i.start_month == 4'd0) ? 4'd1 :
                  (item_i.start_month > 4'd12) ? 4'd12 : item_i.start_month;

  // Year and decade subtrahend; decades as shift-add of 8x plus 2x.
  assign sub_y   = (op_q == OP_DECADES) ?
                   (({4'd0, amt_q} << 3) + ({4'd0, amt_q} << 1)) : {4'd0, amt_q};
  assign y_under = sub_y > year_q;

  // Month step: amt_q already reduced below 12, yc_q holds whole years.
  assign borrow  = {6'd0, month_q} <= amt_q;
  assign m_sub   = month_q + (borrow ? 4'd12 : 4'd0) - amt_q[3:0];
  assign ysub_m  = {7'd0, yc_q} + {13'd0, borrow};
  assign m_under = ysub_m > year_q;

  assign yr_new = (state_q == ST_MAPPLY) ? (year_q - ysub_m) : (year_q - sub_y);

  // Month lengths under the tracker's leap bit.
  assign n_len    = days_in(trk_sts.leap, month_q);
  assign prev_len = days_in(trk_sts.leap, month_q - 4'd1);
  assign clamp_d  = (day_q == 5'd0) ? 5'd1 : (day_q > n_len) ? n_len : day_q;

  // Weeks as 8x minus 1x.
  assign steps_init = (op_q == OP_WEEKS) ?
                      (({3'd0, amt_q} << 3) - {3'd0, amt_q}) : {3'd0, amt_q};

  // Load the tracker on a new year; decrement it on a year wrap.
  always_comb begin
    trk_cmd      = '0;
    trk_cmd.year = yr_new;
    case (state_q)
      ST_IDLE: begin
        trk_cmd.load = start;
        trk_cmd.year = yr_in;
      end
      ST_MAPPLY: trk_cmd.load = !m_under;
      ST_YAPPLY: trk_cmd.load = !y_under;
      ST_DAY: begin
        trk_cmd.dec = (steps_q != '0) && (day_q == 5'd1) && (month_q == 4'd1) &&
                      (year_q != '0);
      end
      default: trk_cmd = trk_cmd;
    endcase
  end

  cds_year_trk u_trk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (trk_cmd),
    .sts_o  (trk_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      done_q   <= 1'b0;
      second_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            op_q     <= item_i.operation;
            amt_q    <= item_i.amount;
            day_q    <= item_i.start_day;
            month_q  <= mon_in;
            year_q   <= yr_in;
            second_q <= 1'b0;
            state_q  <= ST_RED;
          end
        end
        // Hold until the tracker has reduced the year.
        ST_RED: begin
          if (!trk_sts.busy) begin
            state_q <= second_q ? ST_FIN : ST_INIT;
          end
        end
        // Clamp the starting day, then dispatch on the operation.
        ST_INIT: begin
          day_q <= clamp_d;
          case (op_q)
            OP_DAYS, OP_WEEKS: begin
              steps_q <= steps_init;
              state_q <= ST_DAY;
            end
            OP_MONTHS: begin
              yc_q    <= '0;
              state_q <= ST_MDIV;
            end
            OP_YEARS, OP_DECADES: state_q <= ST_YAPPLY;
            default: begin
              result_q <= '{clamp_d, month_q, year_q, 1'b0};
              done_q   <= 1'b1;
              state_q  <= ST_IDLE;
            end
          endcase
        end
        // Step back one day per cycle.
        ST_DAY: begin
          if (steps_q == '0) begin
            result_q <= '{day_q, month_q, year_q, 1'b0};
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else if ((day_q == 5'd1) && (month_q == 4'd1)) begin
            if (year_q == '0) begin
              result_q <= '{5'd1, 4'd1, 14'd0, 1'b1};
              done_q   <= 1'b1;
              state_q  <= ST_IDLE;
            end else begin
              year_q  <= year_q - 14'd1;
              month_q <= 4'd12;
              day_q   <= 5'd31;
              steps_q <= steps_q - 13'd1;
            end
          end else if (day_q == 5'd1) begin
            month_q <= month_q - 4'd1;
            day_q   <= prev_len;
            steps_q <= steps_q - 13'd1;
          end else begin
            day_q   <= day_q - 5'd1;
            steps_q <= steps_q - 13'd1;
          end
        end
        // Split the month count into whole years and a remainder.
        ST_MDIV: begin
          if (amt_q >= 10'd12) begin
            amt_q <= amt_q - 10'd12;
            yc_q  <= yc_q + 7'd1;
          end else begin
            state_q <= ST_MAPPLY;
          end
        end
        ST_MAPPLY: begin
          if (m_under) begin
            result_q <= '{5'd1, 4'd1, 14'd0, 1'b1};
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            month_q  <= m_sub;
            year_q   <= yr_new;
            second_q <= 1'b1;
            state_q  <= ST_RED;
          end
        end
        ST_YAPPLY: begin
          if (y_under) begin
            result_q <= '{5'd1, 4'd1, 14'd0, 1'b1};
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            year_q   <= yr_new;
            second_q <= 1'b1;
            state_q  <= ST_RED;
          end
        end
        // Clamp the day to the target month and drop the beat out.
        ST_FIN: begin
          result_q <= '{clamp_d, month_q, year_q, 1'b0};
          done_q   <= 1'b1;
          state_q  <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // A result beat lands only as the sequencer returns to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result beat while busy");

  // An accepted beat always occupies the sequencer.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

  // Saturated results are exactly 1 January of year 0.
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.year_underflow) |->
      (result_o.result_day == 5'd1 && result_o.result_month == 4'd1 &&
       result_o.result_year == 14'd0)) else $error("bad saturated date");

  // Result months stay in calendar range and result days are at least 1.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.result_month >= 4'd1 && result_o.result_month <= 4'd12 &&
                result_o.result_day >= 5'd1)) else $error("result out of range");

endmodule

// ===== sv/cds_year_trk.sv =====
// Year residue tracker: year mod 100 and century mod 4, giving the leap-year bit.
module cds_year_trk (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cds_pkg::trk_cmd_t cmd_i,
  output cds_pkg::trk_sts_t sts_o
);
  import cds_pkg::*;

  logic [13:0] rem_q;
  logic [1:0]  cent_q;
  logic        run_q;

  // Reduce by repeated subtraction of 100, then track single-year decrements.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      cent_q <= '0;
      run_q  <= 1'b0;
    end else if (cmd_i.load) begin
      rem_q  <= cmd_i.year;
      cent_q <= '0;
      run_q  <= 1'b1;
    end else if (run_q) begin
      if (rem_q >= 14'd100) begin
        rem_q  <= rem_q - 14'd100;
        cent_q <= cent_q + 2'd1;
      end else begin
        run_q <= 1'b0;
      end
    end else if (cmd_i.dec) begin
      if (rem_q == '0) begin
        rem_q  <= 14'd99;
        cent_q <= cent_q - 2'd1;
      end else begin
        rem_q <= rem_q - 14'd1;
      end
    end
  end

  // Year mod 4 equals remainder mod 4 since 100 is a multiple of 4.
  assign sts_o.busy = run_q;
  assign sts_o.leap = ((rem_q != '0) && (rem_q[1:0] == 2'd0)) ||
                      ((rem_q == '0) && (cent_q == 2'd0));

endmodule

// ===== dv/cds_checker.sv =====
`timescale 1ns / 1ps
// Date checker: predicts every accepted date beat and compares it with the core's result.
module cds_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  cds_pkg::in_t  item_i,
  input  logic          done_i,
  input  cds_pkg::out_t result_i,
  output int            mismatch_cnt_o,
  output int            pending_o
);
  import cds_pkg::*;

  out_t due_dates[$];
  int   fails = 0;

  function automatic bit is_leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    if (m == 2) begin
      return is_leap_year(y) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic int unsigned fit_day(int unsigned d, int unsigned y, int unsigned m);
    if (d < 1) begin
      return 1;
    end
    return (d > month_days(y, m)) ? month_days(y, m) : d;
  endfunction

  // Expected date after moving the repaired start date back by the beat's amount.
  function automatic out_t date_minus(in_t it);
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned amt;
    int unsigned steps;
    int unsigned total;
    int unsigned back;
    int unsigned i;
    bit          flag;
    out_t        r;
    d    = it.start_day;
    m    = it.start_month;
    y    = it.start_year;
    amt  = it.amount;
    flag = 1'b0;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (y > MaxYear) y = MaxYear;
    d = fit_day(d, y, m);
    case (it.operation)
      OP_DAYS, OP_WEEKS: begin
        steps = (it.operation == OP_WEEKS) ? 7 * amt : amt;
        i = 0;
        while (i < steps && !flag) begin
          if (d == 1 && m == 1) begin
            if (y == 0) begin
              flag = 1'b1;
            end else begin
              y = y - 1;
              m = 12;
              d = 31;
            end
          end else if (d == 1) begin
            m = m - 1;
            d = month_days(y, m);
          end else begin
            d = d - 1;
          end
          i++;
        end
      end
      OP_MONTHS: begin
        total = y * 12 + (m - 1);
        if (amt > total) begin
          flag = 1'b1;
        end else begin
          total = total - amt;
          y = total / 12;
          m = total % 12 + 1;
          d = fit_day(d, y, m);
        end
      end
      OP_YEARS, OP_DECADES: begin
        back = (it.operation == OP_DECADES) ? amt * 10 : amt;
        if (back > y) begin
          flag = 1'b1;
        end else begin
          y = y - back;
          d = fit_day(d, y, m);
        end
      end
      default: ;
    endcase
    if (flag) begin
      d = 1;
      m = 1;
      y = 0;
    end
    r.result_day     = 5'(d);
    r.result_month   = 4'(m);
    r.result_year    = 14'(y);
    r.year_underflow = flag;
    return r;
  endfunction

  function automatic void check_field(string name, logic [13:0] want, logic [13:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      // Compare first: a result never belongs to a beat taken at the same edge.
      if (done_i === 1'b1) begin
        if (due_dates.size() == 0) begin
          $error("result beat with no date waiting");
          fails++;
        end else begin
          want = due_dates.pop_front();
          check_field("result_day", 14'(want.result_day), 14'(result_i.result_day));
          check_field("result_month", 14'(want.result_month), 14'(result_i.result_month));
          check_field("result_year", want.result_year, result_i.result_year);
          check_field("year_underflow", 14'(want.year_underflow),
                      14'(result_i.year_underflow));
        end
      end
      if (start_i && busy_i === 1'b0) begin
        due_dates.push_back(date_minus(item_i));
      end
    end
    mismatch_cnt_o <= fails;
    pending_o      <= due_dates.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: drives date beats into the subtract core and gives the verdict.
module tb_top;
  import cds_pkg::*;

  // Operation codes the core does not define; they must return the repaired date.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_MID   = 3'd6;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  localparam int RandomBeats = 100;
  localparam int QuietTail   = 20;   // last beats go out back to back

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  in_t  item_i = '0;
  logic done_o;
  out_t result_o;
  int   mismatches;
  int   in_flight;

  // 4 ns clock: two delays, high then low.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  calendar_date_subtract_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  cds_checker u_date_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item_i),
    .done_i         (done_o),
    .result_i       (result_o),
    .mismatch_cnt_o (mismatches),
    .pending_o      (in_flight)
  );

  function automatic in_t date_beat(logic [2:0] op, int amt, int d, int m, int y);
    in_t it;
    it.operation   = op;
    it.amount      = 10'(amt);
    it.start_day   = 5'(d);
    it.start_month = 4'(m);
    it.start_year  = 14'(y);
    return it;
  endfunction

  // Random beat: mostly valid dates, weighted toward year 0, century boundaries
  // and the top of the year range, with some out-of-range fields mixed in.
  function automatic in_t random_date();
    logic [2:0] op;
    int         amt;
    int         d;
    int         m;
    int         y;
    if ($urandom_range(0, 9) == 0) begin
      op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end else begin
      op = 3'($urandom_range(OP_DAYS, OP_DECADES));
    end
    // Keep day and week stepping mostly short, since the core steps back day by day.
    if (op == OP_DAYS || op == OP_WEEKS) begin
      amt = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 60) : $urandom_range(0, 1023);
    end else begin
      amt = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 30) : $urandom_range(0, 1023);
    end
    case ($urandom_range(0, 9))
      0, 1:    y = $urandom_range(0, 12);
      2, 3:    y = 100 * $urandom_range(0, 99) + $urandom_range(0, 4);
      4:       y = $urandom_range(9990, 9999);
      5:       y = $urandom_range(10000, 16383);
      default: y = $urandom_range(0, 9999);
    endcase
    m = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 15);
    case ($urandom_range(0, 4))
      0, 1:    d = $urandom_range(1, 28);
      2, 3:    d = $urandom_range(28, 31);
      default: d = $urandom_range(0, 31);
    endcase
    return date_beat(op, amt, d, m, y);
  endfunction

  // Present one beat and hold it until the core takes it. Start stays high
  // on return so back-to-back beats never toggle it within one step.
  task automatic send_date(in_t it);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Drop start for a random idle burst.
  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 7)) @(posedge clk_i);
  endtask

  // Drop start and hold off until every outstanding date has come back.
  task automatic drain_dates();
    start <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
  endtask

  initial begin
    in_t plan[$];

    // Directed beats: field extremes, every operation, leap rules, clamping,
    // input repair and the saturation at 1 January of year 0.
    plan.push_back(date_beat(OP_DAYS, 0, 15, 6, 2024));
    plan.push_back(date_beat(OP_DAYS, 1, 1, 1, 2000));
    plan.push_back(date_beat(OP_DAYS, 1, 1, 3, 2000));
    plan.push_back(date_beat(OP_DAYS, 1, 1, 3, 1900));
    plan.push_back(date_beat(OP_DAYS, 1023, 31, 12, 9999));
    plan.push_back(date_beat(OP_WEEKS, 1023, 15, 7, 5000));
    plan.push_back(date_beat(OP_DAYS, 1, 1, 1, 0));
    plan.push_back(date_beat(OP_WEEKS, 1, 3, 1, 0));
    plan.push_back(date_beat(OP_MONTHS, 1, 31, 3, 2023));
    plan.push_back(date_beat(OP_MONTHS, 1, 31, 3, 2024));
    plan.push_back(date_beat(OP_MONTHS, 1023, 15, 5, 50));
    plan.push_back(date_beat(OP_MONTHS, 12, 29, 2, 2024));
    plan.push_back(date_beat(OP_YEARS, 1, 29, 2, 2024));
    plan.push_back(date_beat(OP_YEARS, 1023, 10, 10, 9999));
    plan.push_back(date_beat(OP_DECADES, 1023, 1, 1, 9999));
    plan.push_back(date_beat(OP_DECADES, 100, 29, 2, 2000));
    plan.push_back(date_beat(OP_SPARE_FIRST, 5, 31, 4, 2021));
    plan.push_back(date_beat(OP_SPARE_MID, 1023, 0, 0, 16383));
    plan.push_back(date_beat(OP_SPARE_LAST, 7, 17, 15, 300));
    plan.push_back(date_beat(OP_DAYS, 3, 0, 15, 16383));
    plan.push_back(date_beat(OP_MONTHS, 0, 31, 2, 2004));
    plan.push_back(date_beat(OP_YEARS, 0, 31, 2, 1900));
    plan.push_back(date_beat(OP_YEARS, 2, 31, 0, 1));

    // Hold reset, then release it once for the whole run.
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      send_date(plan[i]);
      if ($urandom_range(0, 3) == 0) idle_burst();
    end
    // Let the core fall fully idle once before the random part.
    drain_dates();

    // Random part: idling only in alternate stretches of 16 beats, and none
    // in the tail, so gaps land on every phase of a beat's work.
    for (int n = 0; n < RandomBeats; n++) begin
      send_date(random_date());
      if (n < RandomBeats - QuietTail && (n / 16) % 2 == 0 && $urandom_range(0, 2) == 0) begin
        idle_burst();
      end
      if (n == RandomBeats / 2) drain_dates();
    end

    // Wait out the last results, then a short settle for stray strobes.
    drain_dates();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, worst-case weeks included.
  initial begin
    #15_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cds_pkg.sv
sv/cds_year_trk.sv
sv/calendar_date_subtract_core.sv
dv/cds_checker.sv
dv/tb_top.sv
